@@ rtl/bsdl_pkg.sv @@
// Shared types and codes for the bounded sorted deque list.
// Used by bsdl_cell and bounded_sorted_deque_list; no dependencies.
package bsdl_pkg;

	localparam int VAL_W = 32;
	localparam int OP_W  = 3;
	localparam int STS_W = 2;
	localparam int LEN_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_INSERT     = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_POP_BACK   = 3'd4,
		OP_REMOVE     = 3'd5,
		OP_CLEAR      = 3'd6
	} op_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK   = 2'd0,
		STS_MISS = 2'd1,
		STS_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_SCAN,
		S_APPLY
	} state_t;

	// Which cells raise their match flag during the compare cycle.
	typedef enum logic [2:0] {
		FK_ALL,
		FK_TAIL,
		FK_GE,
		FK_VALID,
		FK_LAST,
		FK_EQ
	} fkind_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_INS,
		SH_REM
	} shift_t;

	typedef struct packed {
		logic                    cmp;
		logic                    scan;
		fkind_t                  fkind;
		shift_t                  shift;
		logic signed [VAL_W-1:0] key;
	} cell_ctrl_t;

endpackage

@@ rtl/bsdl_cell.sv @@
// One list cell: holds an entry, its match flag and the scan state that
// ripples from its left neighbor. Depends on bsdl_pkg.
module bsdl_cell #(
	parameter int CW  = 5,
	parameter int IDX = 0
) (
	input  logic                              clk,
	input  bsdl_pkg::cell_ctrl_t              ctrl,
	input  logic [CW-1:0]                     count,
	input  logic signed [bsdl_pkg::VAL_W-1:0] left_value,
	input  logic                              left_pre,
	input  logic                              left_flag,
	input  logic signed [bsdl_pkg::VAL_W-1:0] left_carry,
	input  logic signed [bsdl_pkg::VAL_W-1:0] right_value,
	output logic signed [bsdl_pkg::VAL_W-1:0] value,
	output logic                              pre,
	output logic                              flag,
	output logic signed [bsdl_pkg::VAL_W-1:0] carry
);
	import bsdl_pkg::*;

	logic signed [VAL_W-1:0] value_q;
	logic signed [VAL_W-1:0] carry_q;
	logic                    flag_q;
	logic                    pre_q;
	logic                    valid;
	logic                    flag_d;

	assign valid = CW'(IDX) < count;

	always_comb begin
		case (ctrl.fkind)
			FK_ALL:   flag_d = 1'b1;
			FK_TAIL:  flag_d = !valid;
			FK_GE:    flag_d = !valid || !(value_q < ctrl.key);
			FK_VALID: flag_d = valid;
			FK_LAST:  flag_d = count == CW'(IDX + 1);
			FK_EQ:    flag_d = valid && (value_q == ctrl.key);
			default:  flag_d = 1'b0;
		endcase
	end

	// pre_q ends up set when some cell to the left raised its flag; the carry
	// brings along the entry of the first flagged cell.
	always_ff @(posedge clk) begin
		if (ctrl.cmp) begin
			flag_q <= flag_d;
			pre_q  <= 1'b0;
		end else if (ctrl.scan) begin
			pre_q   <= left_pre | left_flag;
			carry_q <= (left_flag && !left_pre) ? left_value : left_carry;
		end
		case (ctrl.shift)
			SH_INS: begin
				if (flag_q && !pre_q) begin
					value_q <= ctrl.key;
				end else if (pre_q) begin
					value_q <= left_value;
				end
			end
			SH_REM: begin
				if (flag_q || pre_q) begin
					value_q <= right_value;
				end
			end
			default: begin
			end
		endcase
	end

	assign value = value_q;
	assign pre   = pre_q;
	assign flag  = flag_q;
	assign carry = carry_q;

endmodule

@@ rtl/bounded_sorted_deque_list.sv @@
// Bounded sorted deque list: a row of CAPACITY cells with a small controller.
// An accepted beat goes through the compare, scan and apply states; apply waits
// while the result register holds an untaken beat. A new beat is taken only in
// idle, after the match scan that ripples one cell per cycle along the row.
// Reset: arst_n clears the length, the controller and the output valid;
// entry contents are left as they are.
module bounded_sorted_deque_list #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // value[31:0]
	input  logic [2:0]  s_tuser,  // operation[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // out_value[31:0], length[36:32], zero fill
	output logic [1:0]  m_tuser   // status[1:0]
);
	import bsdl_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = $clog2(CAPACITY);

	state_t                  state_q, state_d;
	logic [OP_W-1:0]         op_q;
	logic signed [VAL_W-1:0] key_q;
	logic [CW-1:0]           count_q, count_d;
	logic [SW-1:0]           scan_q;
	cell_ctrl_t              ctrl;

	logic signed [VAL_W-1:0] cell_value [CAPACITY];
	logic signed [VAL_W-1:0] cell_carry [CAPACITY];
	logic [CAPACITY-1:0]     cell_pre;
	logic [CAPACITY-1:0]     cell_flag;

	logic                    found;
	logic signed [VAL_W-1:0] found_value;
	logic                    full;

	logic                    res_load;
	logic signed [VAL_W-1:0] res_value;
	status_t                 res_status;

	logic                    m_tvalid_q;
	logic signed [VAL_W-1:0] out_value_q;
	status_t                 status_q;
	logic [LEN_W-1:0]        length_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] lv, lc, rv;
		logic                    lp, lf;
		if (i == 0) begin : g_head
			assign lv = '0;
			assign lc = '0;
			assign lp = 1'b0;
			assign lf = 1'b0;
		end else begin : g_body
			assign lv = cell_value[i-1];
			assign lc = cell_carry[i-1];
			assign lp = cell_pre[i-1];
			assign lf = cell_flag[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign rv = cell_value[i];
		end else begin : g_inner
			assign rv = cell_value[i+1];
		end
		bsdl_cell #(
			.CW  (CW),
			.IDX (i)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.count       (count_q),
			.left_value  (lv),
			.left_pre    (lp),
			.left_flag   (lf),
			.left_carry  (lc),
			.right_value (rv),
			.value       (cell_value[i]),
			.pre         (cell_pre[i]),
			.flag        (cell_flag[i]),
			.carry       (cell_carry[i])
		);
	end

	assign found = cell_pre[CAPACITY-1] | cell_flag[CAPACITY-1];
	assign found_value = (cell_flag[CAPACITY-1] && !cell_pre[CAPACITY-1]) ?
		cell_value[CAPACITY-1] : cell_carry[CAPACITY-1];
	assign full = count_q == CW'(CAPACITY);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		res_load   = 1'b0;
		res_value  = '0;
		res_status = STS_OK;
		ctrl.cmp   = 1'b0;
		ctrl.scan  = 1'b0;
		ctrl.fkind = FK_ALL;
		ctrl.shift = SH_NONE;
		ctrl.key   = key_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				ctrl.cmp = 1'b1;
				case (op_q)
					OP_PUSH_FRONT: ctrl.fkind = FK_ALL;
					OP_PUSH_BACK:  ctrl.fkind = FK_TAIL;
					OP_INSERT:     ctrl.fkind = FK_GE;
					OP_POP_FRONT:  ctrl.fkind = FK_VALID;
					OP_POP_BACK:   ctrl.fkind = FK_LAST;
					OP_REMOVE:     ctrl.fkind = FK_EQ;
					default:       ctrl.fkind = FK_ALL;
				endcase
				state_d = S_SCAN;
			end
			S_SCAN: begin
				ctrl.scan = 1'b1;
				if (scan_q == SW'(1)) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				// The row changes only in the cycle the result is loaded into the output register.
				if (!m_tvalid_q || m_tready) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
					case (op_q)
						OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
							if (full) begin
								res_status = STS_FULL;
							end else begin
								ctrl.shift = SH_INS;
								count_d    = count_q + CW'(1);
							end
						end
						OP_POP_FRONT, OP_POP_BACK, OP_REMOVE: begin
							if (found) begin
								ctrl.shift = SH_REM;
								res_value  = found_value;
								count_d    = count_q - CW'(1);
							end else begin
								res_status = STS_MISS;
							end
						end
						OP_CLEAR: begin
							count_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			op_q  <= s_tuser;
			key_q <= s_tdata;
		end
		if (state_q == S_CMP) begin
			scan_q <= SW'(CAPACITY - 1);
		end else if (state_q == S_SCAN) begin
			scan_q <= scan_q - SW'(1);
		end
		if (res_load) begin
			out_value_q <= res_value;
			status_q    <= res_status;
			length_q    <= LEN_W'(count_d);
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, length_q, out_value_q};
	assign m_tuser  = status_q;

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for bounded_sorted_deque_list: directed, fill/drain and random beats.
// Keeps its own copy of the list to predict every result beat.
// Depends on rtl/bsdl_pkg.sv and rtl/bounded_sorted_deque_list.sv.
`timescale 1ns / 1ps

module testbench;
	import bsdl_pkg::*;

	localparam int CAPACITY = 16;
	localparam int LIMIT_CYCLES = 400000;
	localparam int MAX_REPORTS = 200;
	localparam int RANDOM_BEATS = 290;
	// Code 7 is not an operation; the block must answer it with an idle result.
	localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		status_t          status;
		logic [LEN_W-1:0] length;
	} list_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [VAL_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]   s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [39:0]       m_tdata;
	logic [STS_W-1:0]  m_tuser;

	logic signed [VAL_W-1:0] list_entries[$];
	list_result_t            pending_results[$];
	int                      mismatches = 0;
	int                      cycles = 0;
	int                      send_idle_pct = 0;
	int                      stall_pct = 0;

	bounded_sorted_deque_list #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// Applies one operation to the held list and returns the result beat it causes.
	function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
			input logic signed [VAL_W-1:0] val);
		list_result_t r;
		int pos;
		r.value = '0;
		r.status = STS_OK;
		pos = 0;
		case (op)
		OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
			if (list_entries.size() >= CAPACITY)
				r.status = STS_FULL;
			else if (op == OP_PUSH_FRONT)
				list_entries.push_front(val);
			else if (op == OP_PUSH_BACK)
				list_entries.push_back(val);
			else begin
				// Equal values land ahead of the entries already there.
				while (pos < list_entries.size() && list_entries[pos] < val)
					pos++;
				list_entries.insert(pos, val);
			end
		end
		OP_POP_FRONT: begin
			if (list_entries.size() == 0)
				r.status = STS_MISS;
			else
				r.value = list_entries.pop_front();
		end
		OP_POP_BACK: begin
			if (list_entries.size() == 0)
				r.status = STS_MISS;
			else
				r.value = list_entries.pop_back();
		end
		OP_REMOVE: begin
			while (pos < list_entries.size() && list_entries[pos] != val)
				pos++;
			if (pos < list_entries.size()) begin
				r.value = list_entries[pos];
				list_entries.delete(pos);
			end else
				r.status = STS_MISS;
		end
		OP_CLEAR: begin
			list_entries.delete();
		end
		default: begin
		end
		endcase
		r.length = LEN_W'(list_entries.size());
		return r;
	endfunction

	function automatic logic [OP_W-1:0] grow_op();
		case ($urandom_range(2))
		0: return OP_PUSH_FRONT;
		1: return OP_PUSH_BACK;
		default: return OP_INSERT;
		endcase
	endfunction

	function automatic logic [OP_W-1:0] shrink_op();
		case ($urandom_range(3))
		0: return OP_POP_FRONT;
		1: return OP_POP_BACK;
		default: return OP_REMOVE;
		endcase
	endfunction

	// Removal keys mostly hit a held entry; other values mix full range, a
	// narrow band that makes duplicates, the extremes and held entries.
	function automatic logic [VAL_W-1:0] pick_operand(input logic [OP_W-1:0] op);
		int n;
		n = list_entries.size();
		if (op == OP_REMOVE && n != 0 && $urandom_range(3) != 0)
			return list_entries[$urandom_range(n - 1)];
		case ($urandom_range(3))
		0: return $urandom;
		1: return int'($urandom_range(8)) - 4;
		2: begin
			case ($urandom_range(3))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			default: return '1;
			endcase
		end
		default: begin
			if (n != 0)
				return list_entries[$urandom_range(n - 1)];
			return $urandom;
		end
		endcase
	endfunction

	task automatic send_beat(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= val;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(apply_list_op(op, val));
	endtask

	task automatic test_directed();
		send_beat(OP_POP_FRONT, 32'h0000_0000);
		send_beat(OP_POP_BACK, 32'hffff_ffff);
		send_beat(OP_REMOVE, 32'h0000_0000);
		send_beat(OP_SPARE, 32'hffff_ffff);
		send_beat(OP_PUSH_FRONT, 32'h7fff_ffff);
		send_beat(OP_PUSH_BACK, 32'h8000_0000);
		send_beat(OP_INSERT, 32'h0000_0000);
		send_beat(OP_INSERT, 32'h0000_0000);
		send_beat(OP_INSERT, 32'hffff_ffff);
		send_beat(OP_INSERT, 32'h5555_5555);
		send_beat(OP_SPARE, 32'haaaa_aaaa);
		send_beat(OP_REMOVE, 32'h0000_3039);
		send_beat(OP_REMOVE, 32'h0000_0000);
		send_beat(OP_POP_FRONT, 32'h0000_0000);
		send_beat(OP_POP_BACK, 32'h0000_0000);
		send_beat(OP_CLEAR, 32'h1234_5678);
		send_beat(OP_POP_BACK, 32'h0000_0000);
		send_beat(OP_REMOVE, 32'h8000_0000);
	endtask

	// Fills the list to capacity, pushes into it while full, then drains it
	// and pops once more while empty.
	task automatic test_fill_drain();
		logic [OP_W-1:0] op;
		while (list_entries.size() < CAPACITY) begin
			op = grow_op();
			send_beat(op, pick_operand(op));
		end
		repeat (3) begin
			op = grow_op();
			send_beat(op, $urandom);
		end
		while (list_entries.size() > 0) begin
			op = shrink_op();
			send_beat(op, pick_operand(op));
		end
		send_beat(shrink_op(), $urandom);
	endtask

	task automatic test_random_ops(input int beats);
		logic [OP_W-1:0] op;
		int roll;
		int grow_pct;
		repeat (beats) begin
			roll = $urandom_range(99);
			// Lean toward growth on a short list and toward shrinking on a long one.
			grow_pct = 70 - 3 * list_entries.size();
			if (roll < 2)
				op = OP_SPARE;
			else if (roll < 5)
				op = OP_CLEAR;
			else if ($urandom_range(99) < grow_pct)
				op = grow_op();
			else
				op = shrink_op();
			send_beat(op, pick_operand(op));
		end
	endtask

	always @(posedge clk) begin : check_results
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("%0t: expected no beat, got value %0d status %0d length %0d",
						$time, $signed(m_tdata[31:0]), m_tuser, m_tdata[36:32]);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[31:0] !== want.value || m_tuser !== want.status
						|| m_tdata[36:32] !== want.length) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: expected value %0d status %0d length %0d, got value %0d status %0d length %0d",
							$time, $signed(want.value), want.status, want.length,
							$signed(m_tdata[31:0]), m_tuser, m_tdata[36:32]);
					mismatches++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin : run_tests
		int send_idle_by_phase[4];
		int stall_by_phase[4];
		send_idle_by_phase = '{0, 61, 0, 10};
		stall_by_phase = '{0, 0, 61, 10};
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_idle_by_phase[ph];
			stall_pct = stall_by_phase[ph];
			test_fill_drain();
			test_random_ops(RANDOM_BEATS);
		end
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// Give a stray extra beat time to show up.
		repeat (2 * CAPACITY + 8)
			@(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
